// ===== hw/rtl/zve_pkg.sv =====
// Shared types and constants for the varint encoder.
`default_nettype none
package zve_pkg;

  // Width of one input magnitude and of one data group.
  localparam int unsigned MagW   = 64;
  localparam int unsigned GroupW = 7;

  // Encoding modes carried on the command field.
  typedef enum logic {
    CMD_NATURAL = 1'b0,
    CMD_SIGNED  = 1'b1
  } zve_mode_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture a new number into the shift register
    logic shift;  // advance to the next 7-bit group
  } zve_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;   // the current byte is the final one of the number
  } zve_sts_t;

endpackage : zve_pkg
`default_nettype wire

// ===== hw/rtl/zve_datapath.sv =====
// Datapath: the group register and the remaining-magnitude shift register.
`default_nettype none
module zve_datapath
  import zve_pkg::*;
(
  input  wire logic             clk,
  input  wire zve_cmd_t         cmd,
  input  wire logic             in_cmd,
  input  wire logic [MagW-1:0]  in_magnitude,
  input  wire logic             in_negative,
  output zve_sts_t              sts,
  output logic      [7:0]       out_byte,
  output logic                  out_last
);

  logic [GroupW-1:0] cur_r, cur_nxt;
  logic [MagW-1:0]   rest_r, rest_nxt;
  logic              mag_nz;

  // Form the first group and the remainder for the selected mode.
  always_comb begin
    mag_nz   = (in_magnitude != '0);
    cur_nxt  = cur_r;
    rest_nxt = rest_r;
    if (cmd.load) begin
      if (zve_mode_t'(in_cmd) == CMD_SIGNED) begin
        // Sign sits in bit 6; a zero magnitude never carries a sign.
        cur_nxt  = {in_negative & mag_nz, in_magnitude[5:0]};
        rest_nxt = in_magnitude >> 6;
      end else begin
        cur_nxt  = in_magnitude[GroupW-1:0];
        rest_nxt = in_magnitude >> GroupW;
      end
    end else if (cmd.shift) begin
      cur_nxt  = rest_r[GroupW-1:0];
      rest_nxt = rest_r >> GroupW;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    rest_r <= rest_nxt;
  end

  // The byte is final once nothing remains to send.
  assign sts.last = (rest_r == '0);
  assign out_last = sts.last;
  assign out_byte = {~sts.last, cur_r};

endmodule : zve_datapath
`default_nettype wire

// ===== hw/rtl/zve_ctrl.sv =====
// Controller: sequences load and shift commands and drives the handshakes.
`default_nettype none
module zve_ctrl
  import zve_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire zve_sts_t sts,
  output zve_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } zve_state_t;

  zve_state_t state_r, state_nxt;
  logic       in_acc;
  logic       out_acc;

  // A new number is taken when idle or when the final byte leaves this cycle.
  always_comb begin
    out_valid = (state_r == ST_EMIT);
    out_acc   = out_valid & ~out_stall;
    in_stall  = out_valid & ~(out_acc & sts.last);
    in_acc    = in_valid & ~in_stall;
    cmd.load  = in_acc;
    cmd.shift = out_acc & ~sts.last;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (in_acc) begin
          state_nxt = ST_EMIT;
        end else if (out_acc && sts.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : zve_ctrl
`default_nettype wire

// ===== hw/rtl/zarith_varint_encoder.sv =====
// Top level of the variable-length integer encoder.
//
// Input channel (in_valid / in_stall): one beat carries a mode (in_cmd), a
// 64-bit magnitude and a sign flag. Natural mode emits unsigned LEB128;
// signed mode puts six magnitude bits and the sign in the first byte.
// Output channel (out_valid / out_stall): one beat per encoded byte, least
// significant group first, with out_last set on the final byte. Bit 7 of
// out_byte is the continuation flag.
// Latency: the first byte is presented the cycle after the input beat.
// Throughput: a number of N bytes (1 to 10) is sent as N output beats; the
// next number is accepted in the same cycle that the final byte of the
// current one is taken, so back-to-back numbers follow without a gap. The
// limit is the single 64-bit shift register, one group per unstalled cycle.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; anything in flight is discarded.
// While the receiver stalls, the current byte is held unchanged and no new
// number is accepted.
`default_nettype none
module zarith_varint_encoder
  import zve_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic            in_cmd,
  input  wire logic [MagW-1:0] in_magnitude,
  input  wire logic            in_negative,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic      [7:0]      out_byte,
  output logic                 out_last
);

  zve_cmd_t cmd;
  zve_sts_t sts;

  zve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  zve_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .in_cmd       (in_cmd),
    .in_magnitude (in_magnitude),
    .in_negative  (in_negative),
    .sts          (sts),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  // An accepted number always shows a byte in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("no output byte after an accepted input beat");

  // A new number may only enter when the final byte is leaving.
  a_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && out_valid) |-> (out_last && !out_stall))
    else $error("input accepted while earlier bytes remain");

  // Load and shift never both fire.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && cmd.shift))
    else $error("load and shift issued together");

  // A non-final byte that is taken leaves another byte behind.
  a_continue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=> out_valid)
    else $error("encoding ended before its final byte");

endmodule : zarith_varint_encoder
`default_nettype wire

// ===== sim/tb_zarith_varint_encoder.sv =====
// Self-checking testbench for the varint encoder, using directed and random numbers.
module tb_zarith_varint_encoder
  import zve_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // One number sent to the encoder.
  typedef struct {
    zve_mode_t       mode;
    logic [MagW-1:0] magnitude;
    logic            negative;
  } varint_number_t;

  // One encoded byte as it should leave the encoder.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  localparam logic [7:0] ContFlag = 8'h80;
  localparam logic [7:0] SignFlag = 8'h40;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic            in_cmd = 1'b0;
  logic [MagW-1:0] in_magnitude = '0;
  logic            in_negative = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [7:0]      out_byte;
  logic            out_last;

  varint_number_t numbers_to_send[$];
  enc_byte_t      expected_bytes[$];
  varint_number_t next_number;
  enc_byte_t      want_byte;
  int unsigned    numbers_queued = 0;
  int unsigned    numbers_accepted = 0;
  int unsigned    error_count = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  logic           in_beat_taken = 1'b0;

  zarith_varint_encoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_magnitude (in_magnitude),
    .in_negative  (in_negative),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Work out the byte sequence for one number and append it to the expected bytes.
  function automatic void push_encoding(zve_mode_t mode, logic [MagW-1:0] magnitude,
                                        logic negative);
    logic [MagW-1:0] rest;
    logic [7:0]      group;
    if (mode == CMD_NATURAL) begin
      group = {1'b0, magnitude[6:0]};
      rest  = magnitude >> GroupW;
    end else begin
      // Signed mode keeps six magnitude bits; the sign shows only for nonzero values.
      group = {2'b00, magnitude[5:0]};
      if (negative && magnitude != '0) begin
        group = group | SignFlag;
      end
      rest = magnitude >> (GroupW - 1);
    end
    while (rest != '0) begin
      expected_bytes.insert(expected_bytes.size(),
                            enc_byte_t'{data: group | ContFlag, last: 1'b0});
      group = {1'b0, rest[6:0]};
      rest  = rest >> GroupW;
    end
    expected_bytes.insert(expected_bytes.size(), enc_byte_t'{data: group, last: 1'b1});
  endfunction

  function automatic void queue_number(zve_mode_t mode, logic [MagW-1:0] magnitude,
                                       logic negative);
    numbers_to_send.insert(numbers_to_send.size(),
                           varint_number_t'{mode: mode, magnitude: magnitude,
                                            negative: negative});
    numbers_queued++;
  endfunction

  // Random numbers with a spread of encoded lengths: pick a bit width, then fill it.
  task automatic queue_random_numbers(int unsigned count);
    int unsigned     width;
    logic [MagW-1:0] value;
    repeat (count) begin
      width = $urandom_range(MagW, 0);
      value = {$urandom, $urandom};
      if (width < MagW) begin
        value = value & ((64'd1 << width) - 64'd1);
      end
      if (width != 0) begin
        value[width-1] = 1'b1;
      end
      queue_number(zve_mode_t'($urandom_range(1, 0)), value, 1'(($urandom_range(1, 0))));
    end
  endtask

  // Wait until every queued number has been taken and all of its bytes have come back.
  task automatic wait_until_drained();
    while (numbers_accepted != numbers_queued || expected_bytes.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: present the next number at the falling edge, hold it until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (numbers_to_send.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        next_number = numbers_to_send.pop_front();
        in_valid     <= 1'b1;
        in_cmd       <= next_number.mode;
        in_magnitude <= next_number.magnitude;
        in_negative  <= next_number.negative;
      end else begin
        // Idle cycle: scramble the payload, the encoder must ignore it.
        in_valid     <= 1'b0;
        in_cmd       <= 1'($urandom_range(1, 0));
        in_magnitude <= {$urandom, $urandom};
        in_negative  <= 1'($urandom_range(1, 0));
      end
    end
    out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
  end

  // Monitor: predict on each input beat and compare each output beat with the oldest byte.
  always @(posedge clk) begin
    in_beat_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      push_encoding(zve_mode_t'(in_cmd), in_magnitude, in_negative);
      numbers_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h last %0b", $time, out_byte, out_last);
        error_count++;
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_byte !== want_byte.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want_byte.data,
                   out_byte);
          error_count++;
        end
        if (out_last !== want_byte.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want_byte.last,
                   out_last);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed numbers, then random numbers under four idling patterns.
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero in both modes, including a negative zero and a sign in natural mode.
    queue_number(CMD_NATURAL, 64'd0, 1'b0);
    queue_number(CMD_NATURAL, 64'd0, 1'b1);
    queue_number(CMD_SIGNED, 64'd0, 1'b0);
    queue_number(CMD_SIGNED, 64'd0, 1'b1);
    // Group boundaries of the first and second bytes in each mode.
    queue_number(CMD_NATURAL, 64'h7f, 1'b1);
    queue_number(CMD_NATURAL, 64'h80, 1'b0);
    queue_number(CMD_SIGNED, 64'h3f, 1'b0);
    queue_number(CMD_SIGNED, 64'h3f, 1'b1);
    queue_number(CMD_SIGNED, 64'h40, 1'b0);
    queue_number(CMD_SIGNED, 64'h40, 1'b1);
    queue_number(CMD_NATURAL, 64'h3fff, 1'b0);
    queue_number(CMD_NATURAL, 64'h4000, 1'b0);
    queue_number(CMD_SIGNED, 64'h1fff, 1'b1);
    queue_number(CMD_SIGNED, 64'h2000, 1'b1);
    // Widest magnitudes and alternating bit patterns.
    queue_number(CMD_NATURAL, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_number(CMD_NATURAL, 64'hffff_ffff_ffff_ffff, 1'b1);
    queue_number(CMD_SIGNED, 64'hffff_ffff_ffff_ffff, 1'b0);
    queue_number(CMD_SIGNED, 64'hffff_ffff_ffff_ffff, 1'b1);
    queue_number(CMD_NATURAL, 64'h8000_0000_0000_0000, 1'b0);
    queue_number(CMD_SIGNED, 64'h8000_0000_0000_0000, 1'b1);
    queue_number(CMD_NATURAL, 64'h00ff_ffff_ffff_ffff, 1'b0);
    queue_number(CMD_SIGNED, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    queue_number(CMD_NATURAL, 64'h5555_5555_5555_5555, 1'b0);
    queue_number(CMD_SIGNED, 64'h5555_5555_5555_5555, 1'b0);
    queue_random_numbers(20);
    wait_until_drained();

    send_idle_pct  = 84;
    recv_stall_pct = 0;
    queue_random_numbers(20);
    wait_until_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 84;
    queue_random_numbers(20);
    wait_until_drained();

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    queue_random_numbers(20);
    wait_until_drained();

    // Quiet cycles to catch any stray bytes after the last one.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (20) @(negedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, expected_bytes.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("zarith_varint_encoder: match");
    end else begin
      $display("zarith_varint_encoder: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #200000;
    $display("zarith_varint_encoder: mismatch");
    $finish;
  end

endmodule
